// ===== rtl/core/hprc_pkg.sv =====
// ----------------------------------------------------------------------------
// hprc_pkg
// Shared constants, register indexes and angle helpers for the heading PI
// rotation controller.
// ----------------------------------------------------------------------------
package hprc_pkg;

  localparam int ANGLE_FRAC_BITS = 12;

  // pi and pi/2 rounded to the angle fraction
  localparam longint PI_Q_L      = ((64'd205887 << ANGLE_FRAC_BITS) + 64'd32768) >> 16;
  localparam longint HALF_PI_Q_L = ((64'd205887 << ANGLE_FRAC_BITS) + 64'd65536) >> 17;

  // working width for angle sums before wrapping
  localparam int ANG_W = 18;
  // accumulator width for the gain products
  localparam int ACC_W = 26;

  localparam logic signed [ANG_W-1:0] PI_Q      = ANG_W'(PI_Q_L);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q  = ANG_W'(2 * PI_Q_L);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = ANG_W'(HALF_PI_Q_L);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SPEED      = 2'd0,
    REG_PROP_GAIN      = 2'd1,
    REG_INTEG_GAIN     = 2'd2,
    REG_STOP_TOLERANCE = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // Bring an angle back into [-pi, +pi]; inputs stay within a few turns.
  function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] v;
    v = a;
    for (int i = 0; i < 3; i++) begin
      if (v > PI_Q) begin
        v = v - TWO_PI_Q;
      end else if (v < -PI_Q) begin
        v = v + TWO_PI_Q;
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/heading_pi_rotation_controller_top.sv =====
// ----------------------------------------------------------------------------
// heading_pi_rotation_controller_top
// Relative-rotation PI controller with integral clamp and speed saturation.
// ----------------------------------------------------------------------------
// Accepts one item per clock unless out_ready holds back a result, and returns
// one result per item. An input transfer loads the input register; one pass of
// wrap / PI arithmetic, with the two gain multipliers and the accumulate,
// feeds the result register directly. A start item (op 0)
// latches the wrapped target, clears the integral and arms the loop; a tick
// item (op 1) returns left = -cmd, right = cmd, or zero speeds with done_res
// set once the error is within stop_tolerance or when no rotation is armed.
// Write the configuration registers only while no item is in flight.
module heading_pi_rotation_controller_top
  import hprc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic signed [14:0]           heading,
  input  logic signed [15:0]           turn_amount,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [7:0]            left_speed,
  output logic signed [7:0]            right_speed,
  output logic                         done_res,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // configuration
  logic [6:0]  max_speed;
  logic [7:0]  prop_gain;
  logic [7:0]  integ_gain;
  logic [11:0] stop_tolerance;

  // controller state
  logic signed [15:0] target_heading;
  logic signed [15:0] error_sum;
  logic               active;

  // input register
  logic               s1_valid;
  logic               s1_op;
  logic signed [14:0] s1_heading;
  logic signed [15:0] s1_turn;

  logic advance;
  logic s1_fire;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign s1_fire  = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed      <= 7'd100;
      prop_gain      <= 8'd40;
      integ_gain     <= 8'd5;
      stop_tolerance <= 12'd41;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_SPEED:      max_speed      <= cfg_data[6:0];
        REG_PROP_GAIN:      prop_gain      <= cfg_data[7:0];
        REG_INTEG_GAIN:     integ_gain     <= cfg_data[7:0];
        REG_STOP_TOLERANCE: stop_tolerance <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [ANG_W-1:0] start_sum;
  logic signed [ANG_W-1:0] target_wr;
  logic signed [ANG_W-1:0] err;
  logic signed [ANG_W-1:0] err_mag;
  logic                    within_tol;
  logic signed [ANG_W-1:0] sum_raw;
  logic signed [ANG_W-1:0] sum_clamped;
  logic signed [ACC_W-1:0] p_term;
  logic signed [ACC_W-1:0] i_term;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] cmd_full;
  logic signed [ACC_W-1:0] lim;
  logic signed [ACC_W-1:0] cmd_sat;

  logic signed [15:0] target_heading_next;
  logic signed [15:0] error_sum_next;
  logic               active_next;
  logic signed [7:0]  cmd_next;
  logic               done_next;

  always_comb begin
    start_sum  = ANG_W'(s1_heading) + ANG_W'(s1_turn);
    target_wr  = wrap_angle(start_sum);
    err        = wrap_angle(ANG_W'(target_heading) - ANG_W'(s1_heading));
    err_mag    = err[ANG_W-1] ? -err : err;
    within_tol = err_mag <= $signed({{(ANG_W-12){1'b0}}, stop_tolerance});

    sum_raw = ANG_W'(error_sum) + err;
    if (sum_raw > HALF_PI_Q) begin
      sum_clamped = HALF_PI_Q;
    end else if (sum_raw < -HALF_PI_Q) begin
      sum_clamped = -HALF_PI_Q;
    end else begin
      sum_clamped = sum_raw;
    end

    p_term = ACC_W'($signed({1'b0, prop_gain})) * ACC_W'(err);
    i_term = ACC_W'($signed({1'b0, integ_gain})) * ACC_W'(sum_clamped);
    acc    = p_term + i_term;
    // bias negatives so the arithmetic shift truncates toward zero
    acc_adj  = acc + (acc[ACC_W-1] ? ACC_W'((1 << ANGLE_FRAC_BITS) - 1) : ACC_W'(0));
    cmd_full = acc_adj >>> ANGLE_FRAC_BITS;
    lim      = ACC_W'($signed({1'b0, max_speed}));
    if (cmd_full > lim) begin
      cmd_sat = lim;
    end else if (cmd_full < -lim) begin
      cmd_sat = -lim;
    end else begin
      cmd_sat = cmd_full;
    end

    target_heading_next = target_heading;
    error_sum_next      = error_sum;
    active_next         = active;
    cmd_next            = '0;
    done_next           = 1'b1;

    priority if (s1_op == OP_START) begin
      target_heading_next = target_wr[15:0];
      error_sum_next      = '0;
      active_next         = 1'b1;
      done_next           = 1'b0;
    end else if (!active) begin
      done_next = 1'b1;
    end else if (within_tol) begin
      active_next = 1'b0;
    end else begin
      error_sum_next = sum_clamped[15:0];
      cmd_next       = cmd_sat[7:0];
      done_next      = 1'b0;
    end
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      active         <= 1'b0;
      target_heading <= '0;
      error_sum      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s1_fire) begin
        active         <= active_next;
        target_heading <= target_heading_next;
        error_sum      <= error_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op      <= op;
      s1_heading <= heading;
      s1_turn    <= turn_amount;
    end
    if (s1_fire) begin
      left_speed  <= -cmd_next;
      right_speed <= cmd_next;
      done_res    <= done_next;
    end
  end

  // ------------------------------------------------------------ assertions
  a_mirror_speeds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_speed == -right_speed))
    else $error("wheel speeds are not mirrored");

  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (right_speed == 8'sd0))
    else $error("done result with nonzero speed");

  a_sum_clamped: assert property (@(posedge clk) disable iff (rst)
    (ANG_W'(error_sum) <= HALF_PI_Q) && (ANG_W'(error_sum) >= -HALF_PI_Q))
    else $error("integral outside clamp");

  a_target_wrapped: assert property (@(posedge clk) disable iff (rst)
    (ANG_W'(target_heading) <= PI_Q) && (ANG_W'(target_heading) >= -PI_Q))
    else $error("target heading not wrapped");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_op == OP_START) |=> (active && error_sum == 16'sd0))
    else $error("start transfer did not arm the loop");

endmodule

// ===== sim/rotation_check_pkg.sv =====
// ----------------------------------------------------------------------------
// rotation_check_pkg
// Wheel command predictor and result store for the rotation controller bench.
// Tracks target, integral and armed state the same way the block does and
// compares each delivered wheel command against the oldest pending one.
// ----------------------------------------------------------------------------
package rotation_check_pkg;
  import hprc_pkg::*;

  typedef struct {
    logic signed [7:0] left;
    logic signed [7:0] right;
    logic              done;
  } wheel_cmd_t;

  class rotation_scoreboard;
    // pi and pi/2 in Q12 radians
    localparam int ANG_PI      = 12868;
    localparam int ANG_HALF_PI = 6434;

    int max_speed;
    int prop_gain;
    int integ_gain;
    int stop_tol;

    int target;
    int err_accum;
    bit armed;

    wheel_cmd_t pending_cmds[$];

    int errors;
    int n_starts;
    int n_ticks;
    int n_finished;
    int n_saturated;
    int n_clamped;

    function new();
      max_speed   = 100;
      prop_gain   = 40;
      integ_gain  = 5;
      stop_tol    = 41;
      target      = 0;
      err_accum   = 0;
      armed       = 1'b0;
      errors      = 0;
      n_starts    = 0;
      n_ticks     = 0;
      n_finished  = 0;
      n_saturated = 0;
      n_clamped   = 0;
    endfunction

    static function int wrap_q(int a);
      while (a > ANG_PI) a -= 2 * ANG_PI;
      while (a < -ANG_PI) a += 2 * ANG_PI;
      return a;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_MAX_SPEED:      max_speed  = int'(value[6:0]);
        REG_PROP_GAIN:      prop_gain  = int'(value[7:0]);
        REG_INTEG_GAIN:     integ_gain = int'(value[7:0]);
        REG_STOP_TOLERANCE: stop_tol   = int'(value[11:0]);
        default: ;
      endcase
    endfunction

    function void push_cmd(int cmd, logic done);
      wheel_cmd_t c;
      c.left  = 8'(-cmd);
      c.right = 8'(cmd);
      c.done  = done;
      pending_cmds.push_back(c);
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    // Note an accepted input transfer and queue the wheel command it causes.
    function void note_input(op_t kind, int hdg, int turn);
      int err;
      int mag;
      int acc;
      int cmd;
      if (kind == OP_START) begin
        target    = wrap_q(hdg + turn);
        err_accum = 0;
        armed     = 1'b1;
        n_starts++;
        push_cmd(0, 1'b0);
        return;
      end
      n_ticks++;
      if (!armed) begin
        push_cmd(0, 1'b1);
        return;
      end
      err = wrap_q(target - hdg);
      mag = (err < 0) ? -err : err;
      if (mag <= stop_tol) begin
        // finished: the integral keeps its value, the loop disarms
        armed = 1'b0;
        n_finished++;
        push_cmd(0, 1'b1);
        return;
      end
      err_accum += err;
      if (err_accum > ANG_HALF_PI) begin
        err_accum = ANG_HALF_PI;
        n_clamped++;
      end else if (err_accum < -ANG_HALF_PI) begin
        err_accum = -ANG_HALF_PI;
        n_clamped++;
      end
      acc = prop_gain * err + integ_gain * err_accum;
      // shift the magnitude so the command truncates toward zero
      cmd = (acc < 0) ? -((-acc) >> ANGLE_FRAC_BITS) : (acc >> ANGLE_FRAC_BITS);
      if (cmd > max_speed) begin
        cmd = max_speed;
        n_saturated++;
      end else if (cmd < -max_speed) begin
        cmd = -max_speed;
        n_saturated++;
      end
      push_cmd(cmd, 1'b0);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("ERROR: %s", msg);
    endtask

    task check_result(logic signed [7:0] left, logic signed [7:0] right, logic done);
      wheel_cmd_t exp_cmd;
      if (pending_cmds.size() == 0) begin
        report($sformatf("result left %0d right %0d done %0d with nothing pending",
                         left, right, done));
        return;
      end
      exp_cmd = pending_cmds.pop_front();
      if (left !== exp_cmd.left)
        report($sformatf("left_speed %0d, predicted %0d", left, exp_cmd.left));
      if (right !== exp_cmd.right)
        report($sformatf("right_speed %0d, predicted %0d", right, exp_cmd.right));
      if (done !== exp_cmd.done)
        report($sformatf("done_res %0d, predicted %0d", done, exp_cmd.done));
    endtask
  endclass

endpackage

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the heading PI rotation controller.
// Drives start and tick transfers with random gaps on both handshakes, walks
// through several register settings including the extremes, and checks every
// wheel command against a predictor kept alongside the block.
// ----------------------------------------------------------------------------
module tb_top;
  import hprc_pkg::*;
  import rotation_check_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 90;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 92;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  op_t                   op          = OP_START;
  logic signed [14:0]    heading     = '0;
  logic signed [15:0]    turn_amount = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic signed [7:0]     left_speed;
  logic signed [7:0]     right_speed;
  logic                  done_res;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  rotation_scoreboard sb;
  bit src_burst  = 1'b0;
  bit snk_burst  = 1'b0;
  int n_items    = 0;
  int n_results  = 0;
  int n_settings = 0;

  heading_pi_rotation_controller_top uut (
    .clk, .rst,
    .in_valid, .in_ready, .op, .heading, .turn_amount,
    .out_valid, .out_ready, .left_speed, .right_speed, .done_res,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Offer one item; return at the edge where it transfers.
  task automatic send_item(op_t kind, int hdg, int turn);
    int gap;
    if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= kind;
    heading     <= 15'(hdg);
    turn_amount <= 16'(turn);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic write_regs(int spd, int kp, int ki, int tol);
    int       vals[4];
    reg_idx_t idx;
    vals = '{spd, kp, ki, tol};
    for (int i = 0; i < 4; i++) begin
      idx = reg_idx_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      sb.set_reg(idx, CFG_DATA_W'(vals[i]));
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Stop offering, wait for every pending command, then let the pipe empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly start-then-ticks rotations homing on the target, with stray items.
  task automatic run_rotations(int count);
    int sent;
    int target;
    int ticks;
    int err;
    int mode;
    int hdg;
    int turn;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 6) == 0) begin
        send_item(op_t'($urandom_range(0, 1)), rand_span(-16384, 16383),
                  rand_span(-32768, 32767));
        sent++;
      end else begin
        hdg  = rand_span(-16384, 16383);
        turn = $urandom_range(0, 1) ? rand_span(-32768, 32767) : rand_span(-25736, 25736);
        send_item(OP_START, hdg, turn);
        target = rotation_scoreboard::wrap_q(hdg + turn);
        ticks  = rand_span(1, 12);
        sent  += 1 + ticks;
        repeat (ticks) begin
          mode = rand_span(0, 3);
          case (mode)
            0:       err = rand_span(-12868, 12868);
            1:       err = sb.stop_tol + rand_span(-2, 2);
            default: err = rand_span(-200, 200);
          endcase
          if (mode == 1 && $urandom_range(0, 1)) err = -err;
          hdg = (mode == 3) ? rand_span(-16384, 16383)
                            : rotation_scoreboard::wrap_q(target - err);
          send_item(OP_TICK, hdg, rand_span(-32768, 32767));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(op, heading, turn_amount);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(left_speed, right_speed, done_res);
  end

  initial begin : result_sink
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) snk_burst = !snk_burst;
      gap = snk_burst ? 0 : $urandom_range(0, 13);
      // hold off long enough for the block to back up its input
      if (n_results == 120 || n_results == 380) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_results++;
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset register values
    send_item(OP_TICK, 0, 0);                 // tick while idle
    send_item(OP_TICK, -16384, 32767);        // idle tick, field extremes
    send_item(OP_START, 12868, 25736);        // target wraps onto +pi
    send_item(OP_TICK, -12868, 0);            // -pi equals +pi: finishes
    send_item(OP_START, -12868, -25736);      // target wraps onto -pi
    send_item(OP_TICK, 0, 0);                 // saturates, integral clamps
    send_item(OP_TICK, 16383, -32768);        // heading beyond pi
    send_item(OP_TICK, -16384, 0);
    send_item(OP_START, 100, 32767);          // turn beyond 2*pi
    send_item(OP_TICK, 7090, 0);              // error exactly at tolerance
    send_item(OP_TICK, 7090, 0);              // idle again
    send_item(OP_START, 0, -32768);
    send_item(OP_TICK, -6990, 0);             // small negative command rounds to zero
    send_item(OP_START, 0, 1000);             // restart while armed
    send_item(OP_TICK, 0, 0);
    send_item(OP_TICK, 0, 0);
    send_item(OP_TICK, 1000, 0);
    send_item(OP_START, 5000, -5000);
    send_item(OP_TICK, 12000, 0);
    send_item(OP_TICK, 12000, 0);
    send_item(OP_TICK, 0, 0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0:       write_regs(127, 255, 255, 0);
        1:       write_regs(0, 0, 0, 4095);
        2:       write_regs(4095, 0, 255, 1);   // upper data bits dropped
        default: write_regs(rand_span(0, 4095), rand_span(0, 4095),
                            rand_span(0, 4095), rand_span(0, 511));
      endcase
      run_rotations(PHASE_ITEMS);
    end

    drain();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d commands never arrived", sb.pending()));
    $display("Covered %0d transfers in: %0d starts, %0d ticks, %0d finished rotations",
             n_items, sb.n_starts, sb.n_ticks, sb.n_finished);
    $display("Across %0d register settings: %0d saturated commands, %0d integral clamps",
             n_settings, sb.n_saturated, sb.n_clamped);
    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
